// ----- hdl/affine_point_transform_macros.svh -----
// Assertion helpers for the affine transform block
`ifndef AFFINE_POINT_TRANSFORM_MACROS_SVH
`define AFFINE_POINT_TRANSFORM_MACROS_SVH

// Checked on every rising clock edge outside reset
`define APT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Antecedent in this cycle, consequent in the next one
`define APT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/apt_pkg.sv -----
package apt_pkg;

   localparam int unsigned COORD_W = 32;
   localparam int unsigned PROD_W  = 2 * COORD_W;
   localparam int unsigned FRAC_W  = 16;
   localparam int unsigned RND_W   = PROD_W - FRAC_W;
   localparam int unsigned SUM_W   = RND_W + 2;
   localparam int unsigned NUM_ROWS = 3;

   localparam int unsigned CSR_DATA_W = 64;
   localparam int unsigned CSR_ADDR_W = 6;
   localparam int unsigned REG_IDX_W  = 3;
   localparam int unsigned NUM_REGS   = 6;

   localparam logic [REG_IDX_W-1:0] REG_M00_M01 = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_M02_T0  = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_M10_M11 = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_M12_T1  = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_M20_M21 = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_M22_T2  = 3'd5;

   localparam logic [CSR_DATA_W-1:0] Q16_ONE = 64'd65536;

   typedef struct packed {
      logic signed [COORD_W-1:0] in_x;
      logic signed [COORD_W-1:0] in_y;
      logic signed [COORD_W-1:0] in_z;
      logic                      is_direction;
   } req_word_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] out_x;
      logic signed [COORD_W-1:0] out_y;
      logic signed [COORD_W-1:0] out_z;
      logic                      saturated;
   } rsp_word_type;

   // one matrix row plus its translation term
   typedef struct packed {
      logic signed [COORD_W-1:0] c0;
      logic signed [COORD_W-1:0] c1;
      logic signed [COORD_W-1:0] c2;
      logic signed [COORD_W-1:0] t;
   } row_type;

   typedef logic signed [SUM_W-1:0] row_sum_type;

endpackage

// ----- hdl/affine_point_transform.sv -----
// Affine 3D transform: result = M * v + t for a point, M * v for a direction.
// Input channel req_*: one word per accepted edge (req_valid high, req_stall
// low) carrying x, y, z in signed Q16.16 and the direction flag.
// Result channel rsp_*: one word per input word, same order, saturated to
// 32 bits with a flag when any coordinate clipped.
// Configuration: APB-style csr_* port, 64-bit registers at 8-byte spacing,
// pready tied high; write only while no words are in flight.
// Pipeline: three register stages, with rsp_valid driven from the last one.
// Throughput: one word per cycle unless stalled; three lanes (one per
// matrix row) each run a multiply stage and a round/sum stage, then a
// merge stage saturates.
// Stall: each stage loads when empty or when the stage after it moves, so a
// held result leaves room for two more words before req_stall rises.
// Reset: all valid bits clear, matrix returns to identity, translation zero.
`include "affine_point_transform_macros.svh"

module affine_point_transform (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  apt_pkg::req_word_type             req_word,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output apt_pkg::rsp_word_type             rsp_word,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [apt_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [apt_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [apt_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);
   import apt_pkg::*;

   row_type [NUM_ROWS-1:0]     rows;
   row_sum_type [NUM_ROWS-1:0] sums;

   logic vld_a_ff, vld_a_in;
   logic vld_b_ff, vld_b_in;
   logic vld_c_ff, vld_c_in;
   logic point_a_ff, point_a_in;
   logic en_a, en_b, en_c;

   assign en_c = !vld_c_ff || !rsp_stall;
   assign en_b = !vld_b_ff || en_c;
   assign en_a = !vld_a_ff || en_b;

   assign vld_a_in   = en_a ? req_valid : vld_a_ff;
   assign vld_b_in   = en_b ? vld_a_ff : vld_b_ff;
   assign vld_c_in   = en_c ? vld_b_ff : vld_c_ff;
   assign point_a_in = en_a ? !req_word.is_direction : point_a_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
         vld_b_ff <= 1'b0;
         vld_c_ff <= 1'b0;
      end else begin
         vld_a_ff <= vld_a_in;
         vld_b_ff <= vld_b_in;
         vld_c_ff <= vld_c_in;
      end
   end

   always_ff @(posedge clock) begin
      point_a_ff <= point_a_in;
   end

   assign req_stall = !en_a;
   assign rsp_valid = vld_c_ff;

   apt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .rows        (rows)
   );

   for (genvar g = 0; g < NUM_ROWS; g++) begin : g_lane
      apt_lane u_lane (
         .clock   (clock),
         .en_a    (en_a),
         .en_b    (en_b),
         .word    (req_word),
         .point_a (point_a_ff),
         .row     (rows[g]),
         .sum     (sums[g])
      );
   end

   apt_merge u_merge (
      .clock (clock),
      .en_c  (en_c),
      .sums  (sums),
      .word  (rsp_word)
   );

   `APT_ASSERT(a_stall_only_full, !req_stall || (vld_a_ff && vld_b_ff && vld_c_ff && rsp_stall), "input stalled with room in pipeline")
   `APT_ASSERT_NEXT(a_accept_lands, req_valid && !req_stall, vld_a_ff, "accepted word lost at first stage")
   `APT_ASSERT_NEXT(a_rsp_from_b, !rsp_valid, !rsp_valid || $past(vld_b_ff), "result appeared without a summed word")
   `APT_ASSERT(a_sat_at_bound, !(rsp_valid && rsp_word.saturated) || (rsp_word.out_x == {1'b1, {(COORD_W-1){1'b0}}}) || (rsp_word.out_x == {1'b0, {(COORD_W-1){1'b1}}}) || (rsp_word.out_y == {1'b1, {(COORD_W-1){1'b0}}}) || (rsp_word.out_y == {1'b0, {(COORD_W-1){1'b1}}}) || (rsp_word.out_z == {1'b1, {(COORD_W-1){1'b0}}}) || (rsp_word.out_z == {1'b0, {(COORD_W-1){1'b1}}}), "saturation flag without a clipped coordinate")

endmodule

// ----- hdl/apt_csr.sv -----
module apt_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [apt_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [apt_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [apt_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready,
   output apt_pkg::row_type [apt_pkg::NUM_ROWS-1:0] rows
);
   import apt_pkg::*;

   logic [CSR_DATA_W-1:0] regs_ff [NUM_REGS];
   logic [REG_IDX_W-1:0]  idx;
   logic                  wr_en;

   assign csr_pready = 1'b1;
   assign idx        = csr_paddr[CSR_ADDR_W-1:CSR_ADDR_W-REG_IDX_W];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff[REG_M00_M01] <= Q16_ONE;
         regs_ff[REG_M02_T0]  <= '0;
         regs_ff[REG_M10_M11] <= Q16_ONE << COORD_W;
         regs_ff[REG_M12_T1]  <= '0;
         regs_ff[REG_M20_M21] <= '0;
         regs_ff[REG_M22_T2]  <= Q16_ONE;
      end else if (wr_en && (32'(idx) < NUM_REGS)) begin
         regs_ff[idx] <= csr_pwdata;
      end
   end

   always_comb begin
      if (32'(idx) < NUM_REGS) begin
         csr_prdata = regs_ff[idx];
      end else begin
         csr_prdata = '0;
      end
   end

   assign rows[0] = '{c0: regs_ff[REG_M00_M01][COORD_W-1:0],
                      c1: regs_ff[REG_M00_M01][2*COORD_W-1:COORD_W],
                      c2: regs_ff[REG_M02_T0][COORD_W-1:0],
                      t:  regs_ff[REG_M02_T0][2*COORD_W-1:COORD_W]};
   assign rows[1] = '{c0: regs_ff[REG_M10_M11][COORD_W-1:0],
                      c1: regs_ff[REG_M10_M11][2*COORD_W-1:COORD_W],
                      c2: regs_ff[REG_M12_T1][COORD_W-1:0],
                      t:  regs_ff[REG_M12_T1][2*COORD_W-1:COORD_W]};
   assign rows[2] = '{c0: regs_ff[REG_M20_M21][COORD_W-1:0],
                      c1: regs_ff[REG_M20_M21][2*COORD_W-1:COORD_W],
                      c2: regs_ff[REG_M22_T2][COORD_W-1:0],
                      t:  regs_ff[REG_M22_T2][2*COORD_W-1:COORD_W]};

endmodule

// ----- hdl/apt_lane.sv -----
module apt_lane (
   input  logic                  clock,
   input  logic                  en_a,
   input  logic                  en_b,
   input  apt_pkg::req_word_type word,
   input  logic                  point_a,
   input  apt_pkg::row_type      row,
   output apt_pkg::row_sum_type  sum
);
   import apt_pkg::*;

   logic signed [PROD_W-1:0] p0_ff, p1_ff, p2_ff;
   logic signed [PROD_W-1:0] p0_in, p1_in, p2_in;
   logic signed [PROD_W-1:0] r0, r1, r2;
   row_sum_type              sum_ff, sum_in;
   logic signed [SUM_W-1:0]  t_ext;

   assign p0_in = row.c0 * word.in_x;
   assign p1_in = row.c1 * word.in_y;
   assign p2_in = row.c2 * word.in_z;

   always_ff @(posedge clock) begin
      if (en_a) begin
         p0_ff <= p0_in;
         p1_ff <= p1_in;
         p2_ff <= p2_in;
      end
   end

   // round half up to Q16.16
   assign r0 = (p0_ff + PROD_W'(signed'(1 << (FRAC_W - 1)))) >>> FRAC_W;
   assign r1 = (p1_ff + PROD_W'(signed'(1 << (FRAC_W - 1)))) >>> FRAC_W;
   assign r2 = (p2_ff + PROD_W'(signed'(1 << (FRAC_W - 1)))) >>> FRAC_W;

   assign t_ext  = point_a ? SUM_W'(row.t) : '0;
   assign sum_in = SUM_W'(r0) + SUM_W'(r1) + SUM_W'(r2) + t_ext;

   always_ff @(posedge clock) begin
      if (en_b) begin
         sum_ff <= sum_in;
      end
   end

   assign sum = sum_ff;

endmodule

// ----- hdl/apt_merge.sv -----
module apt_merge (
   input  logic                                         clock,
   input  logic                                         en_c,
   input  apt_pkg::row_sum_type [apt_pkg::NUM_ROWS-1:0] sums,
   output apt_pkg::rsp_word_type                        word
);
   import apt_pkg::*;

   logic signed [COORD_W-1:0] sat_val [NUM_ROWS];
   logic [NUM_ROWS-1:0]       clip;
   rsp_word_type              word_ff, word_in;

   always_comb begin
      for (int i = 0; i < NUM_ROWS; i++) begin
         // overflow when the bits above the 32-bit sign do not all match it
         clip[i] = (sums[i][SUM_W-1:COORD_W-1] != '0)
                && (sums[i][SUM_W-1:COORD_W-1] != '1);
         if (!clip[i]) begin
            sat_val[i] = sums[i][COORD_W-1:0];
         end else if (sums[i][SUM_W-1]) begin
            sat_val[i] = {1'b1, {(COORD_W-1){1'b0}}};
         end else begin
            sat_val[i] = {1'b0, {(COORD_W-1){1'b1}}};
         end
      end
      word_in.out_x     = sat_val[0];
      word_in.out_y     = sat_val[1];
      word_in.out_z     = sat_val[2];
      word_in.saturated = |clip;
   end

   always_ff @(posedge clock) begin
      if (en_c) begin
         word_ff <= word_in;
      end
   end

   assign word = word_ff;

endmodule
